>>> sv/gass_pkg.sv
// ----------------------------------------------------------------------------
// gass_pkg
// Shared types, codes and default sizes of the grid A* search core.
// ----------------------------------------------------------------------------
package gass_pkg;

    // Default sizes of the cell store
    localparam int DEF_MAX_COLS  = 64;
    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_COST_BITS = 20;

    // Fixed widths of the stream words and the register port
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_COST_W = 20;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int DIM_W      = 9;

    // Operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_EXPAND = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // Search status codes
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SEARCH = 2'd1;
    localparam logic [1:0] PH_FOUND  = 2'd2;
    localparam logic [1:0] PH_NOPATH = 2'd3;

    // Cell marks
    localparam logic [1:0] MK_NONE   = 2'd0;
    localparam logic [1:0] MK_OPEN   = 2'd1;
    localparam logic [1:0] MK_CLOSED = 2'd2;

    // Parent directions
    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_LEFT  = 3'd1;
    localparam logic [2:0] DIR_RIGHT = 3'd2;
    localparam logic [2:0] DIR_UP    = 3'd3;
    localparam logic [2:0] DIR_DOWN  = 3'd4;

    // Neighbor visit order
    localparam logic [2:0] NB_LEFT  = 3'd0;
    localparam logic [2:0] NB_RIGHT = 3'd1;
    localparam logic [2:0] NB_UP    = 3'd2;
    localparam logic [2:0] NB_DOWN  = 3'd3;
    localparam logic [2:0] NB_END   = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_GRID_W   = 3'd0;
    localparam logic [2:0] REG_GRID_H   = 3'd1;
    localparam logic [2:0] REG_START_X  = 3'd2;
    localparam logic [2:0] REG_START_Y  = 3'd3;
    localparam logic [2:0] REG_GOAL_X   = 3'd4;
    localparam logic [2:0] REG_GOAL_Y   = 3'd5;
    localparam logic [2:0] REG_STRAIGHT = 3'd6;
    localparam logic [2:0] REG_DIAG     = 3'd7;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ_WAIT,
        ST_START_WR,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_SCAN_END,
        ST_NB_SEL,
        ST_NB_UPD,
        ST_DONE
    } state_t;

endpackage

>>> sv/gass_ram.sv
// ----------------------------------------------------------------------------
// gass_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gass_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/gass_heur.sv
// ----------------------------------------------------------------------------
// gass_heur
// Registered octile distance from a cell to the goal, saturated to the
// cost width.
// ----------------------------------------------------------------------------
module gass_heur
    import gass_pkg::*;
#(
    parameter int XW        = 7,
    parameter int COST_BITS = DEF_COST_BITS
) (
    input  logic                 clk,
    input  logic [XW-1:0]        x,
    input  logic [XW-1:0]        y,
    input  logic [5:0]           goal_x,
    input  logic [5:0]           goal_y,
    input  logic [7:0]           straight_cost,
    input  logic [7:0]           diag_cost,
    output logic [COST_BITS-1:0] h
);

    localparam int PW = XW + 9;
    localparam logic [63:0] CMAX = (64'd1 << COST_BITS) - 64'd1;

    logic [XW-1:0]        gx, gy, dx, dy, lo, dd;
    logic [PW-1:0]        full;
    logic [63:0]          full64;
    logic [COST_BITS-1:0] h_next;

    // Distances along each axis, the diagonal part and the straight rest.
    always_comb
    begin
        gx     = XW'(goal_x);
        gy     = XW'(goal_y);
        dx     = (x > gx) ? (x - gx) : (gx - x);
        dy     = (y > gy) ? (y - gy) : (gy - y);
        lo     = (dx < dy) ? dx : dy;
        dd     = (dx > dy) ? (dx - dy) : (dy - dx);
        full   = PW'(lo) * PW'(diag_cost) + PW'(dd) * PW'(straight_cost);
        full64 = 64'(full);
        h_next = (full64 > CMAX) ? '1 : full64[COST_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        h <= h_next;
    end

endmodule

>>> sv/grid_astar_search_step_core.sv
// ----------------------------------------------------------------------------
// grid_astar_search_step_core
// Grid A* engine with four-neighbor moves and an octile heuristic.
// ----------------------------------------------------------------------------
// Every input word gives exactly one result word. A clear sweeps the search
// memory one cell a cycle. An expand step scans the whole search memory
// through its single read port for the best open cell, one cell a cycle,
// and then reads and writes back up to four neighbors. The first step of a
// search closes the start cell without a scan. After reset both memories are
// swept to zero, during which no word is accepted; register writes are taken
// at any time. The next word is accepted while a result still waits on the
// output side.
// ----------------------------------------------------------------------------
module grid_astar_search_step_core
    import gass_pkg::*;
#(
    parameter int MAX_COLS  = DEF_MAX_COLS,
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int COST_BITS = DEF_COST_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [1:0] opcode, [7:2] cell_x, [13:8] cell_y, [14] obstacle_bit
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] search_status, [7:2] closed_x, [13:8] closed_y, [15:14] cell_mark,
    // [16] cell_blocked, [19:17] parent_dir, [39:20] g_value, [59:40] f_value
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int NCELLS = MAX_COLS * MAX_ROWS;
    localparam int AW     = $clog2(NCELLS);
    localparam int XW     = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;
    localparam int YW     = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
    localparam int CW     = XW > YW ? XW : YW;
    localparam int SW     = $clog2(NCELLS) + 1;
    localparam int CB     = COST_BITS;
    // Search word layout: mark, parent, g, h, f, open stamp
    localparam int G_LO   = 5;
    localparam int H_LO   = 5 + CB;
    localparam int F_LO   = 5 + 2 * CB;
    localparam int S_LO   = 5 + 3 * CB;
    localparam int WW     = 5 + 3 * CB + SW;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [6:0] grid_w_reg, grid_h_reg;
    logic [5:0] start_x_reg, start_y_reg, goal_x_reg, goal_y_reg;
    logic [7:0] straight_reg, diag_reg;
    logic       cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg   <= 7'd64;
            grid_h_reg   <= 7'd64;
            start_x_reg  <= 6'd0;
            start_y_reg  <= 6'd0;
            goal_x_reg   <= 6'd63;
            goal_y_reg   <= 6'd63;
            straight_reg <= 8'd10;
            diag_reg     <= 8'd14;
        end
        else if (cfg_we)
        begin
            unique case (paddr[4:2])
                REG_GRID_W:   grid_w_reg   <= pwdata[6:0];
                REG_GRID_H:   grid_h_reg   <= pwdata[6:0];
                REG_START_X:  start_x_reg  <= pwdata[5:0];
                REG_START_Y:  start_y_reg  <= pwdata[5:0];
                REG_GOAL_X:   goal_x_reg   <= pwdata[5:0];
                REG_GOAL_Y:   goal_y_reg   <= pwdata[5:0];
                REG_STRAIGHT: straight_reg <= pwdata[7:0];
                REG_DIAG:     diag_reg     <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (paddr[4:2])
            REG_GRID_W:   prdata = APB_DATA_W'(grid_w_reg);
            REG_GRID_H:   prdata = APB_DATA_W'(grid_h_reg);
            REG_START_X:  prdata = APB_DATA_W'(start_x_reg);
            REG_START_Y:  prdata = APB_DATA_W'(start_y_reg);
            REG_GOAL_X:   prdata = APB_DATA_W'(goal_x_reg);
            REG_GOAL_Y:   prdata = APB_DATA_W'(goal_y_reg);
            REG_STRAIGHT: prdata = APB_DATA_W'(straight_reg);
            REG_DIAG:     prdata = APB_DATA_W'(diag_reg);
            default:      prdata = '0;
        endcase
    end

    // Grid size in use, clamped to the store.
    logic [DIM_W-1:0] eff_w, eff_h;
    assign eff_w = (DIM_W'(grid_w_reg) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                             : DIM_W'(grid_w_reg);
    assign eff_h = (DIM_W'(grid_h_reg) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                             : DIM_W'(grid_h_reg);

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] cx,
                                              input logic [CW-1:0] cy);
        return AW'(32'(cy) * MAX_COLS + 32'(cx));
    endfunction

    // ------------------------------------------------------------------
    // Memories: obstacle bits and search words
    // ------------------------------------------------------------------
    logic          b_we, s_we;
    logic [AW-1:0] b_waddr, s_waddr, rd_addr;
    logic          b_wdata, b_rdata;
    logic [WW-1:0] s_wdata, s_rdata;

    gass_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_blk_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (rd_addr),
        .rdata (b_rdata)
    );

    gass_ram #(.WIDTH(WW), .DEPTH(NCELLS)) u_srch_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (rd_addr),
        .rdata (s_rdata)
    );

    // Fields of the search word just read.
    logic [1:0]    rd_mark;
    logic [2:0]    rd_par;
    logic [CB-1:0] rd_g, rd_h, rd_f;
    logic [SW-1:0] rd_stamp;
    assign rd_mark  = s_rdata[1:0];
    assign rd_par   = s_rdata[4:2];
    assign rd_g     = s_rdata[G_LO +: CB];
    assign rd_h     = s_rdata[H_LO +: CB];
    assign rd_f     = s_rdata[F_LO +: CB];
    assign rd_stamp = s_rdata[S_LO +: SW];

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [1:0]    phase_reg, phase_next;
    logic [SW-1:0] stamp_cnt_reg, stamp_cnt_next;
    logic [SW-1:0] open_cnt_reg, open_cnt_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          clr_all_reg, clr_all_next;
    logic [1:0]    op_reg, op_next;
    logic [5:0]    ix_reg, ix_next, iy_reg, iy_next;

    // Cell under expansion
    logic [CW-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [CB-1:0] cur_g_reg, cur_g_next;
    logic          found_reg, found_next;

    // Neighbor in flight
    logic [2:0]    nb_k_reg, nb_k_next;
    logic [CW-1:0] nb_x_reg, nb_x_next, nb_y_reg, nb_y_next;
    logic [2:0]    nb_dir_reg, nb_dir_next;

    // Scan counters, read pipeline and best open cell so far
    logic [CW-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic          pv_reg, pv_next;
    logic [CW-1:0] px_reg, px_next, py_reg, py_next;
    logic          have_reg, have_next;
    logic [CW-1:0] bx_reg, bx_next, by_reg, by_next;
    logic [2:0]    bpar_reg, bpar_next;
    logic [CB-1:0] bg_reg, bg_next, bh_reg, bh_next, bf_reg, bf_next;
    logic [SW-1:0] bs_reg, bs_next;

    // Pending result and output register
    logic [OUT_DATA_W-1:0] res_reg, res_next;
    logic                  mv_reg, mv_next;
    logic [OUT_DATA_W-1:0] mdata_reg, mdata_next;

    // Heuristic of the neighbor being read
    logic [CW-1:0] hx, hy;
    logic [CB-1:0] nb_h;

    gass_heur #(.XW(CW), .COST_BITS(CB)) u_heur (
        .clk           (clk),
        .x             (hx),
        .y             (hy),
        .goal_x        (goal_x_reg),
        .goal_y        (goal_y_reg),
        .straight_cost (straight_reg),
        .diag_cost     (diag_reg),
        .h             (nb_h)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            phase_reg     <= PH_IDLE;
            stamp_cnt_reg <= '0;
            open_cnt_reg  <= '0;
            clr_addr_reg  <= '0;
            clr_all_reg   <= 1'b1;
            pv_reg        <= 1'b0;
            have_reg      <= 1'b0;
            found_reg     <= 1'b0;
            nb_k_reg      <= NB_LEFT;
            mv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            stamp_cnt_reg <= stamp_cnt_next;
            open_cnt_reg  <= open_cnt_next;
            clr_addr_reg  <= clr_addr_next;
            clr_all_reg   <= clr_all_next;
            pv_reg        <= pv_next;
            have_reg      <= have_next;
            found_reg     <= found_next;
            nb_k_reg      <= nb_k_next;
            mv_reg        <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        ix_reg     <= ix_next;
        iy_reg     <= iy_next;
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        cur_g_reg  <= cur_g_next;
        nb_x_reg   <= nb_x_next;
        nb_y_reg   <= nb_y_next;
        nb_dir_reg <= nb_dir_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        bpar_reg   <= bpar_next;
        bg_reg     <= bg_next;
        bh_reg     <= bh_next;
        bf_reg     <= bf_next;
        bs_reg     <= bs_next;
        res_reg    <= res_next;
        mdata_reg  <= mdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;

    // Decoded input word
    logic [1:0] in_op;
    logic [5:0] in_x, in_y;
    logic       in_ob, in_acc;
    assign in_op  = s_tdata[1:0];
    assign in_x   = s_tdata[7:2];
    assign in_y   = s_tdata[13:8];
    assign in_ob  = s_tdata[14];
    assign in_acc = s_tvalid & s_tready;

    // Shared helper signals
    logic          start_in, in_addr_ok, reg_addr_ok, out_free, scan_last;
    logic          nb_ok, better;
    logic [CW-1:0] nbx_c, nby_c;
    logic [2:0]    nbdir_c;
    logic [CB:0]   cost_sum, f_sum;
    logic [CB-1:0] cost, g_new, f_new;
    logic [2:0]    par_new;

    assign start_in    = (DIM_W'(start_x_reg) < eff_w) && (DIM_W'(start_y_reg) < eff_h);
    assign in_addr_ok  = (32'(in_x) < MAX_COLS) && (32'(in_y) < MAX_ROWS);
    assign reg_addr_ok = (32'(ix_reg) < MAX_COLS) && (32'(iy_reg) < MAX_ROWS);
    assign out_free    = !mv_reg || m_tready;
    assign scan_last   = (32'(sx_reg) == MAX_COLS - 1) && (32'(sy_reg) == MAX_ROWS - 1);

    // Neighbor coordinates for the current visit slot.
    always_comb
    begin
        nbx_c   = cur_x_reg;
        nby_c   = cur_y_reg;
        nbdir_c = DIR_NONE;
        nb_ok   = 1'b0;
        case (nb_k_reg)
            NB_LEFT:
            begin
                nbx_c   = cur_x_reg - CW'(1);
                nbdir_c = DIR_RIGHT;
                nb_ok   = (cur_x_reg != '0);
            end
            NB_RIGHT:
            begin
                nbx_c   = cur_x_reg + CW'(1);
                nbdir_c = DIR_LEFT;
                nb_ok   = 1'b1;
            end
            NB_UP:
            begin
                nby_c   = cur_y_reg - CW'(1);
                nbdir_c = DIR_DOWN;
                nb_ok   = (cur_y_reg != '0);
            end
            NB_DOWN:
            begin
                nby_c   = cur_y_reg + CW'(1);
                nbdir_c = DIR_UP;
                nb_ok   = 1'b1;
            end
            default: nb_ok = 1'b0;
        endcase
        nb_ok = nb_ok && (DIM_W'(nbx_c) < eff_w) && (DIM_W'(nby_c) < eff_h);
    end

    // Relaxation arithmetic for the neighbor just read.
    always_comb
    begin
        cost_sum = {1'b0, cur_g_reg} + (CB + 1)'(straight_reg);
        cost     = cost_sum[CB] ? '1 : cost_sum[CB-1:0];
        if ((rd_mark == MK_NONE) || (cost < rd_g))
        begin
            g_new   = cost;
            par_new = nb_dir_reg;
        end
        else
        begin
            g_new   = rd_g;
            par_new = rd_par;
        end
        f_sum = {1'b0, g_new} + {1'b0, nb_h};
        f_new = f_sum[CB] ? '1 : f_sum[CB-1:0];
    end

    // Scan compare: lower f, then lower h, then earlier stamp.
    assign better = (rd_mark == MK_OPEN) &&
                    (!have_reg || (rd_f < bf_reg) ||
                     ((rd_f == bf_reg) && ((rd_h < bh_reg) ||
                      ((rd_h == bh_reg) && (rd_stamp < bs_reg)))));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (32'(clr_addr_reg) == NCELLS - 1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_op)
                        OP_WRITE:  state_next = ST_DONE;
                        OP_CLEAR:  state_next = ST_CLEAR;
                        OP_READ:   state_next = ST_READ_WAIT;
                        OP_EXPAND:
                        begin
                            if (phase_reg == PH_SEARCH)
                                state_next = ST_SCAN;
                            else if (phase_reg == PH_IDLE && start_in)
                                state_next = ST_START_WR;
                            else
                                state_next = ST_DONE;
                        end
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (32'(clr_addr_reg) == NCELLS - 1)
                    state_next = ST_DONE;
            end
            ST_READ_WAIT: state_next = ST_DONE;
            ST_START_WR:
            begin
                if (start_x_reg == goal_x_reg && start_y_reg == goal_y_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_NB_SEL;
            end
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_SCAN_LAST;
            end
            ST_SCAN_LAST: state_next = ST_SCAN_END;
            ST_SCAN_END:  state_next = have_reg ? ST_NB_SEL : ST_DONE;
            ST_NB_SEL:
            begin
                if (nb_k_reg == NB_END)
                    state_next = ST_DONE;
                else if (nb_ok)
                    state_next = ST_NB_UPD;
            end
            ST_NB_UPD:    state_next = ST_NB_SEL;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory control
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next     = phase_reg;
        stamp_cnt_next = stamp_cnt_reg;
        open_cnt_next  = open_cnt_reg;
        clr_addr_next  = clr_addr_reg;
        clr_all_next   = clr_all_reg;
        op_next        = op_reg;
        ix_next        = ix_reg;
        iy_next        = iy_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        cur_g_next     = cur_g_reg;
        found_next     = found_reg;
        nb_k_next      = nb_k_reg;
        nb_x_next      = nb_x_reg;
        nb_y_next      = nb_y_reg;
        nb_dir_next    = nb_dir_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        pv_next        = 1'b0;
        px_next        = sx_reg;
        py_next        = sy_reg;
        have_next      = have_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        bpar_next      = bpar_reg;
        bg_next        = bg_reg;
        bh_next        = bh_reg;
        bf_next        = bf_reg;
        bs_next        = bs_reg;
        res_next       = res_reg;
        mv_next        = mv_reg;
        mdata_next     = mdata_reg;
        b_we           = 1'b0;
        b_waddr        = clr_addr_reg;
        b_wdata        = 1'b0;
        s_we           = 1'b0;
        s_waddr        = clr_addr_reg;
        s_wdata        = '0;
        rd_addr        = addr_of(sx_reg, sy_reg);
        hx             = nbx_c;
        hy             = nby_c;

        // Output word leaves on its handshake.
        if (mv_reg && m_tready)
            mv_next = 1'b0;

        unique case (state_reg)
            // Sweep after reset clears obstacles and search words alike; a clear sweeps only the search words.
            ST_INIT, ST_CLEAR:
            begin
                s_we          = 1'b1;
                b_we          = clr_all_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (32'(clr_addr_reg) == NCELLS - 1)
                begin
                    clr_addr_next = '0;
                    clr_all_next  = 1'b0;
                end
            end

            ST_IDLE:
            begin
                if (in_acc)
                begin
                    op_next  = in_op;
                    ix_next  = in_x;
                    iy_next  = in_y;
                    res_next = '0;
                    rd_addr  = addr_of(CW'(in_x), CW'(in_y));
                    unique case (in_op)
                        OP_WRITE:
                        begin
                            b_we    = in_addr_ok;
                            b_waddr = addr_of(CW'(in_x), CW'(in_y));
                            b_wdata = in_ob;
                        end
                        OP_CLEAR:
                        begin
                            phase_next     = PH_IDLE;
                            stamp_cnt_next = '0;
                            open_cnt_next  = '0;
                            clr_addr_next  = '0;
                        end
                        OP_EXPAND:
                        begin
                            if (phase_reg == PH_IDLE)
                            begin
                                rd_addr = addr_of(CW'(start_x_reg), CW'(start_y_reg));
                                if (!start_in)
                                    phase_next = PH_NOPATH;
                            end
                            sx_next   = '0;
                            sy_next   = '0;
                            have_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end

            // Read back of one cell.
            ST_READ_WAIT:
            begin
                if (reg_addr_ok)
                begin
                    res_next[15:14] = rd_mark;
                    res_next[16]    = b_rdata;
                    res_next[19:17] = rd_par;
                    res_next[39:20] = OUT_COST_W'(rd_g);
                    res_next[59:40] = OUT_COST_W'(rd_f);
                end
            end

            // First step closes the start cell.
            ST_START_WR:
            begin
                s_we          = 1'b1;
                s_waddr       = addr_of(CW'(start_x_reg), CW'(start_y_reg));
                s_wdata       = {s_rdata[WW-1:2], MK_CLOSED};
                cur_x_next    = CW'(start_x_reg);
                cur_y_next    = CW'(start_y_reg);
                cur_g_next    = rd_g;
                found_next    = 1'b0;
                nb_k_next     = NB_LEFT;
                res_next[7:2]  = start_x_reg;
                res_next[13:8] = start_y_reg;
                if (start_x_reg == goal_x_reg && start_y_reg == goal_y_reg)
                    phase_next = PH_FOUND;
            end

            // One cell read per cycle; each is compared in the following cycle.
            ST_SCAN, ST_SCAN_LAST:
            begin
                if (state_reg == ST_SCAN)
                begin
                    pv_next = 1'b1;
                    if (32'(sx_reg) == MAX_COLS - 1)
                    begin
                        sx_next = '0;
                        sy_next = sy_reg + CW'(1);
                    end
                    else
                    begin
                        sx_next = sx_reg + CW'(1);
                    end
                end
                if (pv_reg && better)
                begin
                    have_next = 1'b1;
                    bx_next   = px_reg;
                    by_next   = py_reg;
                    bpar_next = rd_par;
                    bg_next   = rd_g;
                    bh_next   = rd_h;
                    bf_next   = rd_f;
                    bs_next   = rd_stamp;
                end
            end

            // Close the best open cell, or report no path.
            ST_SCAN_END:
            begin
                if (have_reg)
                begin
                    s_we    = 1'b1;
                    s_waddr = addr_of(bx_reg, by_reg);
                    s_wdata = {bs_reg, bf_reg, bh_reg, bg_reg, bpar_reg, MK_CLOSED};
                    if (open_cnt_reg != '0)
                        open_cnt_next = open_cnt_reg - SW'(1);
                    cur_x_next     = bx_reg;
                    cur_y_next     = by_reg;
                    cur_g_next     = bg_reg;
                    found_next     = 1'b0;
                    nb_k_next      = NB_LEFT;
                    res_next[7:2]  = 6'(bx_reg);
                    res_next[13:8] = 6'(by_reg);
                end
                else
                begin
                    phase_next = PH_NOPATH;
                end
            end

            // Pick the next neighbor and start its read.
            ST_NB_SEL:
            begin
                rd_addr     = addr_of(nbx_c, nby_c);
                nb_x_next   = nbx_c;
                nb_y_next   = nby_c;
                nb_dir_next = nbdir_c;
                if (nb_k_reg == NB_END)
                begin
                    if (found_reg)
                        phase_next = PH_FOUND;
                    else if (open_cnt_reg == '0)
                        phase_next = PH_NOPATH;
                    else
                        phase_next = PH_SEARCH;
                end
                else if (!nb_ok)
                begin
                    nb_k_next = nb_k_reg + 3'd1;
                end
            end

            // Open or re-parent the neighbor; the goal only takes a parent.
            ST_NB_UPD:
            begin
                nb_k_next = nb_k_reg + 3'd1;
                s_waddr   = addr_of(nb_x_reg, nb_y_reg);
                if (rd_mark != MK_CLOSED && !b_rdata)
                begin
                    s_we = 1'b1;
                    if (nb_x_reg == CW'(goal_x_reg) && nb_y_reg == CW'(goal_y_reg))
                    begin
                        s_wdata    = {s_rdata[WW-1:5], nb_dir_reg, rd_mark};
                        found_next = 1'b1;
                    end
                    else if (rd_mark == MK_NONE)
                    begin
                        s_wdata        = {stamp_cnt_reg, f_new, nb_h, g_new, par_new, MK_OPEN};
                        stamp_cnt_next = stamp_cnt_reg + SW'(1);
                        open_cnt_next  = open_cnt_reg + SW'(1);
                    end
                    else
                    begin
                        s_wdata = {rd_stamp, f_new, nb_h, g_new, par_new, rd_mark};
                    end
                end
            end

            // Hand the result to the output register.
            ST_DONE:
            begin
                if (out_free)
                begin
                    mv_next          = 1'b1;
                    mdata_next       = res_reg;
                    mdata_next[1:0]  = phase_reg;
                end
            end

            default: ;
        endcase
    end

`ifndef SYNTH
    // A cell is never written with a mark code that has no meaning.
    a_mark_code: assert property (@(posedge clk) disable iff (!rst_n)
        s_we |-> (s_wdata[1:0] != 2'd3))
        else $error("search word written with an invalid mark");

    // Open cells are a subset of all cells ever opened in this search.
    a_open_le_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        open_cnt_reg <= stamp_cnt_reg)
        else $error("open count exceeds number of opened cells");

    // A clear always returns the search to idle.
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && op_reg == OP_CLEAR) |-> (phase_reg == PH_IDLE))
        else $error("clear did not return the search to idle");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid A* search core. A behavioral copy of the
// engine predicts the result word of every accepted input word; the checker
// compares each result word field by field, in order. Directed tests cover
// cell access, the default grid and the corner cases of a search; random
// searches on small grids follow, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb;
    import gass_pkg::*;

    localparam int NCOLS    = DEF_MAX_COLS;
    localparam int NROWS    = DEF_MAX_ROWS;
    localparam int NCELLS   = NCOLS * NROWS;
    localparam longint COST_TOP = (64'd1 << DEF_COST_BITS) - 1;

    typedef struct {
        logic [1:0]  status;
        logic [5:0]  cx;
        logic [5:0]  cy;
        logic [1:0]  mark;
        logic        blocked;
        logic [2:0]  dir;
        logic [19:0] g;
        logic [19:0] f;
    } result_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    // Shadow of the engine state.
    bit          blk_m [NCELLS];
    logic [1:0]  mark_m [NCELLS];
    logic [2:0]  dir_m [NCELLS];
    longint      g_m [NCELLS];
    longint      h_m [NCELLS];
    longint      f_m [NCELLS];
    int          stamp_m [NCELLS];
    int          next_stamp;
    int          open_cells;
    logic [1:0]  search_phase;

    // Shadow of the registers.
    int grid_w, grid_h, sx, sy, gx, gy, step_cost, diag_cost;

    result_t expected_results[$];
    int      error_count;
    bit      calm;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    grid_astar_search_step_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    function automatic longint clip(longint v);
        return (v > COST_TOP) ? COST_TOP : v;
    endfunction

    function automatic bit on_grid(int x, int y);
        int w;
        int h;
        w = (grid_w > NCOLS) ? NCOLS : grid_w;
        h = (grid_h > NROWS) ? NROWS : grid_h;
        return (x < w) && (y < h);
    endfunction

    function automatic longint octile(int x, int y);
        longint dx;
        longint dy;
        longint lo;
        longint dd;
        dx = (x > gx) ? x - gx : gx - x;
        dy = (y > gy) ? y - gy : gy - y;
        lo = (dx < dy) ? dx : dy;
        dd = (dx > dy) ? dx - dy : dy - dx;
        return clip(lo * diag_cost + dd * step_cost);
    endfunction

    function automatic void wipe_search();
        for (int i = 0; i < NCELLS; i++)
        begin
            mark_m[i]  = MK_NONE;
            dir_m[i]   = DIR_NONE;
            g_m[i]     = 0;
            h_m[i]     = 0;
            f_m[i]     = 0;
            stamp_m[i] = 0;
        end
        next_stamp   = 0;
        open_cells   = 0;
        search_phase = PH_IDLE;
    endfunction

    // Open or re-parent one neighbor of the expanded cell.
    function automatic void relax(int m, int nx, int ny, logic [2:0] dir, ref bit found);
        int i;
        longint cost;
        if (!on_grid(nx, ny))
            return;
        i = ny * NCOLS + nx;
        if (mark_m[i] == MK_CLOSED || blk_m[i])
            return;
        if (nx == gx && ny == gy)
        begin
            dir_m[i] = dir;
            found = 1'b1;
            return;
        end
        cost = clip(g_m[m] + step_cost);
        if (mark_m[i] == MK_NONE || cost < g_m[i])
        begin
            dir_m[i] = dir;
            g_m[i]   = cost;
        end
        h_m[i] = octile(nx, ny);
        f_m[i] = clip(g_m[i] + h_m[i]);
        if (mark_m[i] == MK_NONE)
        begin
            mark_m[i]  = MK_OPEN;
            stamp_m[i] = next_stamp++;
            open_cells++;
        end
    endfunction

    // One expansion step; fills the closed cell when one is closed.
    function automatic void expand_step(ref result_t r);
        int x;
        int y;
        int m;
        bit found;
        bit have;
        found = 1'b0;
        have  = 1'b0;
        m     = 0;
        if (search_phase == PH_IDLE)
        begin
            if (!on_grid(sx, sy))
            begin
                search_phase = PH_NOPATH;
                return;
            end
            x = sx;
            y = sy;
            m = y * NCOLS + x;
            mark_m[m] = MK_CLOSED;
            r.cx = 6'(x);
            r.cy = 6'(y);
            if (x == gx && y == gy)
            begin
                search_phase = PH_FOUND;
                return;
            end
        end
        else
        begin
            for (int i = 0; i < NCELLS; i++)
            begin
                if (mark_m[i] != MK_OPEN)
                    continue;
                if (!have || f_m[i] < f_m[m] ||
                    (f_m[i] == f_m[m] && (h_m[i] < h_m[m] ||
                     (h_m[i] == h_m[m] && stamp_m[i] < stamp_m[m]))))
                begin
                    m = i;
                    have = 1'b1;
                end
            end
            if (!have)
            begin
                search_phase = PH_NOPATH;
                return;
            end
            mark_m[m] = MK_CLOSED;
            if (open_cells > 0)
                open_cells--;
            x = m % NCOLS;
            y = m / NCOLS;
            r.cx = 6'(x);
            r.cy = 6'(y);
        end
        if (x > 0)
            relax(m, x - 1, y, DIR_RIGHT, found);
        relax(m, x + 1, y, DIR_LEFT, found);
        if (y > 0)
            relax(m, x, y - 1, DIR_DOWN, found);
        relax(m, x, y + 1, DIR_UP, found);
        search_phase = found ? PH_FOUND : ((open_cells == 0) ? PH_NOPATH : PH_SEARCH);
    endfunction

    // Result word of one input word; updates the shadow state.
    function automatic result_t predict_result(logic [1:0] op, int x, int y, bit ob);
        result_t r;
        int i;
        r = '{default: '0};
        i = y * NCOLS + x;
        case (op)
            OP_WRITE:  blk_m[i] = ob;
            OP_CLEAR:  wipe_search();
            OP_EXPAND:
            begin
                if (search_phase == PH_IDLE || search_phase == PH_SEARCH)
                    expand_step(r);
            end
            default:
            begin
                r.mark    = mark_m[i];
                r.blocked = blk_m[i];
                r.dir     = dir_m[i];
                r.g       = g_m[i][19:0];
                r.f       = f_m[i][19:0];
            end
        endcase
        r.status = search_phase;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("tb: mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $time);
        error_count++;
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result word", 1, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("search_status", m_tdata[1:0], want.status);
                if (m_tdata[7:2] !== want.cx)
                    report_mismatch("closed_x", m_tdata[7:2], want.cx);
                if (m_tdata[13:8] !== want.cy)
                    report_mismatch("closed_y", m_tdata[13:8], want.cy);
                if (m_tdata[15:14] !== want.mark)
                    report_mismatch("cell_mark", m_tdata[15:14], want.mark);
                if (m_tdata[16] !== want.blocked)
                    report_mismatch("cell_blocked", m_tdata[16], want.blocked);
                if (m_tdata[19:17] !== want.dir)
                    report_mismatch("parent_dir", m_tdata[19:17], want.dir);
                if (m_tdata[39:20] !== want.g)
                    report_mismatch("g_value", m_tdata[39:20], want.g);
                if (m_tdata[59:40] !== want.f)
                    report_mismatch("f_value", m_tdata[59:40], want.f);
            end
        end
    end

    // Output back-pressure.
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(99) >= 20);
    end

    // Send one input word and queue its expected result.
    task automatic send_word(logic [1:0] op, int x, int y, bit ob);
        while (!calm && $urandom_range(99) < 20)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {1'b0, ob, y[5:0], x[5:0], op};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.insert(expected_results.size(), predict_result(op, x, y, ob));
    endtask

    task automatic drain();
        @(posedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(logic [2:0] idx, int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_GRID_W:   grid_w = value & 8'h7F;
            REG_GRID_H:   grid_h = value & 8'h7F;
            REG_START_X:  sx = value & 8'h3F;
            REG_START_Y:  sy = value & 8'h3F;
            REG_GOAL_X:   gx = value & 8'h3F;
            REG_GOAL_Y:   gy = value & 8'h3F;
            REG_STRAIGHT: step_cost = value & 8'hFF;
            default:      diag_cost = value & 8'hFF;
        endcase
    endtask

    task automatic setup_search(int w, int h, int x0, int y0, int x1, int y1, int sc, int dc);
        drain();
        write_reg(REG_GRID_W, w);
        write_reg(REG_GRID_H, h);
        write_reg(REG_START_X, x0);
        write_reg(REG_START_Y, y0);
        write_reg(REG_GOAL_X, x1);
        write_reg(REG_GOAL_Y, y1);
        write_reg(REG_STRAIGHT, sc);
        write_reg(REG_DIAG, dc);
    endtask

    task automatic test_cell_access();
        send_word(OP_WRITE, 63, 63, 1'b1);
        send_word(OP_WRITE, 0, 0, 1'b1);
        send_word(OP_READ, 63, 63, 1'b0);
        send_word(OP_READ, 0, 0, 1'b0);
        send_word(OP_WRITE, 0, 0, 1'b0);
        send_word(OP_WRITE, 63, 63, 1'b0);
        send_word(OP_READ, 42, 21, 1'b0);
    endtask

    task automatic test_default_grid();
        send_word(OP_CLEAR, 0, 0, 1'b0);
        send_word(OP_EXPAND, 0, 0, 1'b0);
        send_word(OP_EXPAND, 0, 0, 1'b0);
        send_word(OP_READ, 1, 0, 1'b0);
        send_word(OP_READ, 0, 1, 1'b0);
    endtask

    task automatic test_corner_cases();
        // Start on the goal: found at once, then the status repeats.
        setup_search(4, 4, 2, 1, 2, 1, 255, 1);
        send_word(OP_CLEAR, 0, 0, 1'b0);
        send_word(OP_EXPAND, 0, 0, 1'b0);
        send_word(OP_EXPAND, 0, 0, 1'b0);
        // Empty grid puts the start outside; oversized height is clamped.
        setup_search(0, 127, 0, 0, 63, 63, 1, 255);
        send_word(OP_CLEAR, 0, 0, 1'b0);
        send_word(OP_EXPAND, 0, 0, 1'b0);
        // Obstacle on the goal makes it unreachable.
        setup_search(2, 2, 0, 0, 1, 1, 10, 14);
        send_word(OP_WRITE, 1, 1, 1'b1);
        send_word(OP_CLEAR, 0, 0, 1'b0);
        repeat (3) send_word(OP_EXPAND, 0, 0, 1'b0);
        send_word(OP_WRITE, 1, 1, 1'b0);
        // Obstacle on the start is expanded all the same.
        setup_search(2, 1, 0, 0, 1, 0, 7, 9);
        send_word(OP_WRITE, 0, 0, 1'b1);
        send_word(OP_CLEAR, 0, 0, 1'b0);
        send_word(OP_EXPAND, 0, 0, 1'b0);
        send_word(OP_READ, 1, 0, 1'b0);
        send_word(OP_WRITE, 0, 0, 1'b0);
    endtask

    task automatic test_random_searches(int rounds);
        int w;
        int h;
        for (int r = 0; r < rounds; r++)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 6);
            h = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 6);
            setup_search(w, h,
                         ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(5),
                         ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(5),
                         ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(5),
                         ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(5),
                         $urandom_range(1, 255), $urandom_range(1, 255));
            calm = (r == 2);
            // Obstacles mostly inside the small grid, some anywhere.
            repeat ($urandom_range(4))
                send_word(OP_WRITE, $urandom_range(5), $urandom_range(5),
                          1'($urandom_range(1)));
            if ($urandom_range(3) == 0)
                send_word(OP_WRITE, $urandom_range(63), $urandom_range(63),
                          1'($urandom_range(1)));
            if ($urandom_range(7) != 0)
                send_word(OP_CLEAR, 0, 0, 1'b0);
            for (int k = 0; k < 6; k++)
            begin
                send_word(OP_EXPAND, $urandom_range(63), $urandom_range(63),
                          1'($urandom_range(1)));
                if (search_phase == PH_FOUND || search_phase == PH_NOPATH)
                    break;
            end
            send_word(OP_READ, gx, gy, 1'b0);
            repeat ($urandom_range(1, 3))
                send_word(OP_READ, $urandom_range(5), $urandom_range(5),
                          1'($urandom_range(1)));
            if ($urandom_range(3) == 0)
                send_word(OP_READ, $urandom_range(63), $urandom_range(63), 1'b0);
            calm = 1'b0;
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        calm     = 1'b0;
        error_count = 0;
        for (int i = 0; i < NCELLS; i++)
            blk_m[i] = 1'b0;
        wipe_search();
        grid_w = 64;
        grid_h = 64;
        sx = 0;
        sy = 0;
        gx = 63;
        gy = 63;
        step_cost = 10;
        diag_cost = 14;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_cell_access();
        test_default_grid();
        test_corner_cases();
        test_random_searches(10);

        drain();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Run limit.
    initial
    begin
        #5000000;
        $display("tb: errors");
        $finish;
    end

endmodule

>>> filelist.f
sv/gass_pkg.sv
sv/gass_ram.sv
sv/gass_heur.sv
sv/grid_astar_search_step_core.sv
verif/tb.sv
